/* rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, parse phases and length constants for the frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int LENGTH_WIDTH = 64;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] CNT_LAST16   = 3'd1;
  localparam logic [2:0] CNT_LAST64   = 3'd7;
  localparam logic [2:0] CNT_KEY_LAST = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } wsd_phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } wsd_beat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic       empty_frame;
  } wsd_result_t;

endpackage

`default_nettype wire

/* rtl/wsd_if.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Ready/valid channels for the raw byte stream and the payload results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic       empty_frame;

  modport source (output valid, output payload_byte, output frame_last,
                  output empty_frame, input ready);
  modport sink (input valid, input payload_byte, input frame_last,
                input empty_frame, output ready);
endinterface

`default_nettype wire

/* rtl/wsd_in_stage.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer input register
// Holds one raw byte beat and releases it when the result side has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_in_stage (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire  [7:0]         in_byte_i,
  output logic               in_ready_o,
  input  wire                space_i,
  output wsd_pkg::wsd_beat_t beat_o
);
  import wsd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       advance;
  logic       load;

  assign advance    = valid_q && space_i;
  assign in_ready_o = !valid_q || advance;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign beat_o.valid = advance;
  assign beat_o.data  = byte_q;

endmodule

`default_nettype wire

/* rtl/wsd_parser.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer header parser and unmasker
// Tracks the frame header, the length counter and the mask key, and turns
// each payload byte into one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wsd_pkg::wsd_beat_t   beat_i,
  output wsd_pkg::wsd_result_t result_o
);
  import wsd_pkg::*;

  wsd_phase_e              phase_q, phase_d;
  logic                    mask_q, mask_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic                    ovf_q, ovf_d;
  logic [2:0]              cnt_q, cnt_d;
  logic [31:0]             key_q, key_d;
  logic [1:0]              kpos_q, kpos_d;

  always_comb begin
    logic [7:0]              b;
    logic [LENGTH_WIDTH-1:0] len_new;
    logic [LENGTH_WIDTH-1:0] len_sat;
    logic                    ovf_new;
    logic                    len_end;
    logic                    hdr_end;
    logic [LENGTH_WIDTH-1:0] hdr_len;
    logic [7:0]              key_byte;
    logic [LENGTH_WIDTH-1:0] rem_dec;

    b        = beat_i.data;
    phase_d  = phase_q;
    mask_d   = mask_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    kpos_d   = kpos_q;
    len_new  = rem_q;
    ovf_new  = ovf_q;
    len_end  = 1'b0;
    hdr_end  = 1'b0;
    hdr_len  = rem_q;
    key_byte = key_q[31:24];
    rem_dec  = rem_q - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
    result_o = '0;

    unique case (phase_q)
      PH_HDR0: begin
        phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        mask_d  = b[7];
        key_d   = '0;
        cnt_d   = '0;
        ovf_d   = 1'b0;
        ovf_new = 1'b0;
        if (b[6:0] == LEN_EXT16) begin
          rem_d   = '0;
          phase_d = PH_EXT16;
        end else if (b[6:0] == LEN_EXT64) begin
          rem_d   = '0;
          phase_d = PH_EXT64;
        end else begin
          len_new = {{(LENGTH_WIDTH-7){1'b0}}, b[6:0]};
          len_end = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_new = {rem_q[LENGTH_WIDTH-9:0], b};
        ovf_new = ovf_q || (rem_q[LENGTH_WIDTH-1:LENGTH_WIDTH-8] != 8'd0);
        rem_d   = len_new;
        ovf_d   = ovf_new;
        if (cnt_q == ((phase_q == PH_EXT16) ? CNT_LAST16 : CNT_LAST64)) begin
          len_end = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], b};
        if (cnt_q >= CNT_KEY_LAST) begin
          hdr_end = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_DATA: begin
        unique case (kpos_q)
          2'd0: key_byte = key_q[31:24];
          2'd1: key_byte = key_q[23:16];
          2'd2: key_byte = key_q[15:8];
          default: key_byte = key_q[7:0];
        endcase
        kpos_d = kpos_q + 2'd1;
        rem_d  = rem_dec;
        result_o.valid        = 1'b1;
        result_o.payload_byte = mask_q ? (b ^ key_byte) : b;
        result_o.frame_last   = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        phase_d = PH_HDR1;
      end
    endcase

    len_sat = ovf_new ? {LENGTH_WIDTH{1'b1}} : len_new;

    if (len_end) begin
      rem_d   = len_sat;
      ovf_d   = 1'b0;
      cnt_d   = '0;
      hdr_len = len_sat;
      if (mask_d) begin
        phase_d = PH_KEY;
      end else begin
        hdr_end = 1'b1;
      end
    end

    if (hdr_end) begin
      kpos_d = '0;
      cnt_d  = '0;
      if (hdr_len == '0) begin
        phase_d              = PH_HDR0;
        result_o.valid       = 1'b1;
        result_o.frame_last  = 1'b1;
        result_o.empty_frame = 1'b1;
      end else begin
        phase_d = PH_DATA;
      end
    end

    result_o.valid = result_o.valid && beat_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      mask_q  <= 1'b0;
      rem_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      key_q   <= '0;
      kpos_q  <= '0;
    end else if (beat_i.valid) begin
      phase_q <= phase_d;
      mask_q  <= mask_d;
      rem_q   <= rem_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      kpos_q  <= kpos_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/wsd_out_stage.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wsd_pkg::wsd_result_t result_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [7:0]           payload_byte_o,
  output logic                 frame_last_o,
  output logic                 empty_frame_o
);
  import wsd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] payload_q;
  logic       last_q;
  logic       empty_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      payload_q <= result_i.payload_byte;
      last_q    <= result_i.frame_last;
      empty_q   <= result_i.empty_frame;
    end
  end

  assign out_valid_o    = valid_q;
  assign payload_byte_o = payload_q;
  assign frame_last_o   = last_q;
  assign empty_frame_o  = empty_q;

endmodule

`default_nettype wire

/* rtl/websocket_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Strips frame headers from a byte stream, unmasks payload bytes and flags
// the last byte of each frame.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Beat contents
//   s_byte_i   in         in_byte: one raw byte of the frame stream
//   m_result_o out        payload_byte, frame_last, empty_frame
//
// One byte beat is taken every cycle while the result register has room.
// A byte is registered in the input register and, once the result register has
// room, its result is registered there. Header and key bytes give no result,
// but an empty frame's last header byte gives one; each payload byte gives one.
// Reset returns the parser to the first header byte and empties both registers.
// A stalled result side holds the input register and then drops ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire           clk_i,
  input  wire           rst_ni,
  wsd_byte_if.sink      s_byte_i,
  wsd_result_if.source  m_result_o
);
  import wsd_pkg::*;

  wsd_beat_t   beat;
  wsd_result_t result;
  logic        space;

  wsd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_byte_i.valid),
    .in_byte_i  (s_byte_i.in_byte),
    .in_ready_o (s_byte_i.ready),
    .space_i    (space),
    .beat_o     (beat)
  );

  wsd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .result_o (result)
  );

  wsd_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_i       (result),
    .space_o        (space),
    .out_valid_o    (m_result_o.valid),
    .out_ready_i    (m_result_o.ready),
    .payload_byte_o (m_result_o.payload_byte),
    .frame_last_o   (m_result_o.frame_last),
    .empty_frame_o  (m_result_o.empty_frame)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds back-to-back frames into the deframer one byte per beat and checks
// every payload beat against an in-bench model of the frame parser. It runs
// directed header corner cases, then random frames with random stalls on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wsd_pkg::*;

  localparam int          BYTE_TARGET   = 1450;
  localparam int          WATCHDOG_MAX  = 5000;
  localparam int          HOLD_CYCLES   = 64;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          REPORT_MAX    = 10;
  localparam logic [63:0] LEN_CAP       = {64{1'b1}} >> (64 - LENGTH_WIDTH);

  localparam int ENC_SHORT = 0;
  localparam int ENC_EXT16 = 1;
  localparam int ENC_EXT64 = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last_flag;
    logic       empty_flag;
  } payload_beat_t;

  logic clk_i;
  logic rst_ni;

  wsd_byte_if   byte_ch ();
  wsd_result_if result_ch ();

  websocket_frame_deframer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_byte_i   (byte_ch),
    .m_result_o (result_ch)
  );

  logic [7:0]    raw_byte_q[$];
  payload_beat_t payload_q[$];
  int            bytes_total;
  int            bytes_sent;
  int            mismatches;
  int            quiet_cycles;
  int            hold_left;
  bit            hold_done;

  wsd_phase_e  prs_phase;
  logic        prs_masked;
  logic [63:0] prs_remaining;
  logic [2:0]  prs_count;
  logic [31:0] prs_key;
  logic [1:0]  prs_key_pos;

  task automatic append_raw(input logic [7:0] v);
    raw_byte_q = {raw_byte_q, v};
  endtask

  task automatic append_payload(input payload_beat_t p);
    payload_q = {payload_q, p};
  endtask

  function automatic int idle_percent(input bit sender);
    if (bytes_sent < bytes_total / 3) begin
      return sender ? 32 : 70;
    end else if (bytes_sent < (2 * bytes_total) / 3) begin
      return sender ? 70 : 32;
    end
    return 0;
  endfunction

  task automatic close_header();
    prs_key_pos = '0;
    prs_count   = '0;
    if (prs_remaining == 0) begin
      prs_phase = PH_HDR0;
      append_payload('{data: 8'h00, last_flag: 1'b1, empty_flag: 1'b1});
    end else begin
      prs_phase = PH_DATA;
    end
  endtask

  task automatic close_length();
    if (prs_remaining > LEN_CAP) begin
      prs_remaining = LEN_CAP;
    end
    prs_count = '0;
    if (prs_masked) begin
      prs_phase = PH_KEY;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [2:0] last_idx;
    logic [7:0] value;
    case (prs_phase)
      PH_HDR1: begin
        len7       = b[6:0];
        prs_masked = b[7];
        prs_key    = '0;
        prs_count  = '0;
        if (len7 == LEN_EXT16) begin
          prs_remaining = '0;
          prs_phase     = PH_EXT16;
        end else if (len7 == LEN_EXT64) begin
          prs_remaining = '0;
          prs_phase     = PH_EXT64;
        end else begin
          prs_remaining = {57'd0, len7};
          close_length();
        end
      end
      PH_EXT16, PH_EXT64: begin
        last_idx      = (prs_phase == PH_EXT16) ? CNT_LAST16 : CNT_LAST64;
        prs_remaining = {prs_remaining[55:0], b};
        if (prs_count == last_idx) begin
          close_length();
        end else begin
          prs_count = prs_count + 3'd1;
        end
      end
      PH_KEY: begin
        prs_key = {prs_key[23:0], b};
        if (prs_count >= CNT_KEY_LAST) begin
          close_header();
        end else begin
          prs_count = prs_count + 3'd1;
        end
      end
      PH_DATA: begin
        value = b;
        if (prs_masked) begin
          value = value ^ prs_key[8 * (3 - prs_key_pos) +: 8];
        end
        prs_key_pos   = prs_key_pos + 2'd1;
        prs_remaining = prs_remaining - 64'd1;
        if (prs_remaining == 0) begin
          prs_phase = PH_HDR0;
        end
        append_payload('{data: value, last_flag: (prs_remaining == 0),
                         empty_flag: 1'b0});
      end
      default: begin
        prs_phase = PH_HDR1;
      end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned len;
    int          pick;
    int          enc;
    bit          masked;
    rst_ni               = 1'b0;
    byte_ch.valid        = 1'b0;
    byte_ch.in_byte      = 8'h00;
    result_ch.ready      = 1'b0;
    bytes_sent           = 0;
    mismatches           = 0;
    quiet_cycles         = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    prs_phase            = PH_HDR0;
    prs_masked           = 1'b0;
    prs_remaining        = '0;
    prs_count            = '0;
    prs_key              = '0;
    prs_key_pos          = '0;

    // Empty frame, masked two-byte frame, zero extended length, and a
    // non-minimal 64-bit length with a masked single byte.
    raw_byte_q = {8'h81, 8'h00,
                  8'hFF, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF,
                  8'h00, 8'h7E, 8'h00, 8'h00,
                  8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 8'h3C};

    while (raw_byte_q.size() < BYTE_TARGET) begin
      masked = $urandom_range(1);
      pick   = $urandom_range(99);
      if (pick < 10) begin
        len = 0;
      end else if (pick < 85) begin
        len = $urandom_range(24, 1);
      end else if (pick < 95) begin
        len = $urandom_range(125, 25);
      end else begin
        len = $urandom_range(300, 126);
      end
      pick = $urandom_range(99);
      if (len >= 126) begin
        enc = (pick < 80) ? ENC_EXT16 : ENC_EXT64;
      end else if (pick < 70) begin
        enc = ENC_SHORT;
      end else if (pick < 90) begin
        enc = ENC_EXT16;
      end else begin
        enc = ENC_EXT64;
      end
      append_raw(8'($urandom));
      if (enc == ENC_SHORT) begin
        append_raw({masked, len[6:0]});
      end else if (enc == ENC_EXT16) begin
        append_raw({masked, LEN_EXT16});
        append_raw(len[15:8]);
        append_raw(len[7:0]);
      end else begin
        append_raw({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) begin
          append_raw(8'(64'(len) >> (8 * i)));
        end
      end
      if (masked) begin
        repeat (4) append_raw(8'($urandom));
      end
      repeat (len) append_raw(8'($urandom));
    end
    bytes_total = raw_byte_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_byte_q.size() != 0 || payload_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && payload_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        deframe_byte(byte_ch.in_byte);
        void'(raw_byte_q.pop_front());
        bytes_sent <= bytes_sent + 1;
      end
      if (byte_ch.valid && !byte_ch.ready) begin
        byte_ch.valid <= 1'b1;
      end else if (raw_byte_q.size() != 0 &&
                   $urandom_range(99) >= idle_percent(1'b1)) begin
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= raw_byte_q[0];
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : payload_monitor
    payload_beat_t want;
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        if (payload_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected payload beat data=%02h last=%b empty=%b",
                     $realtime, result_ch.payload_byte, result_ch.frame_last,
                     result_ch.empty_frame);
          end
        end else begin
          want = payload_q.pop_front();
          if (result_ch.payload_byte !== want.data ||
              result_ch.frame_last !== want.last_flag ||
              result_ch.empty_frame !== want.empty_flag) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: beat mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                       $realtime, want.data, want.last_flag, want.empty_flag,
                       result_ch.payload_byte, result_ch.frame_last,
                       result_ch.empty_frame);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && bytes_sent >= (2 * bytes_total) / 3 + 20) begin
        hold_left       <= HOLD_CYCLES;
        hold_done       <= 1'b1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= idle_percent(1'b0));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
